/* src/llh_pkg.sv */
// Shared constants, handshake types and bucket mapping functions for the latency histogram.
package llh_pkg;

    localparam int LINEAR_LIMIT    = 64;
    localparam int SUB_BUCKET_BITS = 5;
    localparam int BUCKET_COUNT    = 1888;
    localparam int SUB_COUNT       = 1 << SUB_BUCKET_BITS;
    localparam int IDX_W           = $clog2(BUCKET_COUNT);
    localparam int LAST_IDX        = BUCKET_COUNT - 1;

    localparam int VAL_W     = 63;
    localparam int MSB_STEPS = $clog2(VAL_W);
    localparam int E_W       = $clog2(VAL_W + 1);
    localparam int STEP_W    = $clog2(MSB_STEPS);

    localparam logic [VAL_W-1:0] MAX63 = {VAL_W{1'b1}};

    localparam logic [1:0] FN_RECORD = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic             go;
        logic [VAL_W-1:0] value;
    } t_msb_req;

    typedef struct packed {
        logic           done;
        logic [E_W-1:0] e;
    } t_msb_rsp;

    function automatic logic [IDX_W-1:0] bucket_index(input logic [VAL_W-1:0] v,
                                                       input logic [E_W-1:0] e);
        int          shift;
        logic [VAL_W-1:0] sub;
        logic [31:0] full;
        shift = int'(e) - SUB_BUCKET_BITS;
        if (shift < 1) shift = 1;
        sub  = (v >> shift) & VAL_W'(SUB_COUNT - 1);
        full = 32'(LINEAR_LIMIT) + 32'((shift - 1) << SUB_BUCKET_BITS) + sub[31:0];
        if (v < VAL_W'(LINEAR_LIMIT)) full = v[31:0];
        if (full > 32'(LAST_IDX)) full = 32'(LAST_IDX);
        return full[IDX_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] bucket_upper(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] off;
        int               shift;
        logic [63:0]      base;
        logic [63:0]      mask;
        if (idx < IDX_W'(LINEAR_LIMIT)) return VAL_W'(idx);
        off   = idx - IDX_W'(LINEAR_LIMIT);
        shift = int'(off >> SUB_BUCKET_BITS) + 1;
        if (shift + SUB_BUCKET_BITS + 1 > VAL_W) return MAX63;
        base = 64'(SUB_COUNT + int'(off & IDX_W'(SUB_COUNT - 1))) << shift;
        mask = (64'd1 << shift) - 64'd1;
        return VAL_W'(base | mask);
    endfunction

endpackage

/* src/llh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module llh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1888
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/llh_mul.sv */
// Shared 32x32 multiplier with registered product.
module llh_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* src/llh_msb.sv */
// Iterative leading-one search: binary halving, one step per cycle.
module llh_msb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  llh_pkg::t_msb_req i_req,
    output llh_pkg::t_msb_rsp o_rsp
);

    import llh_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [VAL_W-1:0]   r_t;
    logic [E_W-1:0]     r_e;
    logic [E_W-1:0]     w_span;
    logic [VAL_W-1:0]   w_shifted;

    assign w_span    = E_W'(1 << (MSB_STEPS - 1)) >> r_step;
    assign w_shifted = r_t >> w_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_t    <= i_req.value;
                r_e    <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_shifted != '0) begin
                    r_t <= w_shifted;
                    r_e <= r_e + w_span;
                end
                if (r_step == STEP_W'(MSB_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.e    = r_e;

endmodule

/* src/log_linear_latency_histogram_unit.sv */
// Log-linear latency histogram: record, percentile query and clear under one sequencer.
// One word is taken when start is high and busy is low; its result appears on the
// outputs for one cycle with o_strobe, and the receiver cannot stall it. A record
// runs the six-step leading-one search and two passes through the shared 32x32
// multiplier before the bucket read-modify-write. A query walks the buckets up to
// the one that reaches the rank (index at most 1887), and skips the rank multiply
// when the quantile is 1.0 or more: the walk reads one bucket per cycle from the
// single RAM read port; an empty histogram answers at once. Clear and reset sweep
// all 1888 buckets, one per cycle; busy stays high through the sweep that follows
// reset.
module log_linear_latency_histogram_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_sample_value,
    input  logic [31:0] i_occurrence_count,
    input  logic [16:0] i_quantile_q16,
    output logic        o_strobe,
    output logic [62:0] o_percentile_value,
    output logic [63:0] o_total_count,
    output logic [63:0] o_sum_total,
    output logic [62:0] o_min_seen,
    output logic [62:0] o_max_seen,
    output logic        o_is_empty
);

    import llh_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_SRCH = 4'd2;
    localparam logic [3:0] S_IDX  = 4'd3;
    localparam logic [3:0] S_MUL0 = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_PROD = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_QM0  = 4'd8;
    localparam logic [3:0] S_QM1  = 4'd9;
    localparam logic [3:0] S_QTGT = 4'd10;
    localparam logic [3:0] S_QCLP = 4'd11;
    localparam logic [3:0] S_WALK = 4'd12;
    localparam logic [3:0] S_BND  = 4'd13;
    localparam logic [3:0] S_CAP  = 4'd14;

    logic [3:0]       r_state;
    logic             r_strobe;
    logic             r_clr_rpt;
    logic [VAL_W-1:0] r_v;
    logic [31:0]      r_occ;
    logic [15:0]      r_q;
    logic [IDX_W-1:0] r_idx;
    logic [63:0]      r_plo;
    logic [63:0]      r_prod;
    logic             r_psat;
    logic [63:0]      r_count;
    logic [63:0]      r_sum;
    logic [VAL_W-1:0] r_max;
    logic [VAL_W-1:0] r_min;
    logic [63:0]      r_target;
    logic [63:0]      r_seen;
    logic [IDX_W-1:0] r_ptr;
    logic             r_live;
    logic             r_dv;
    logic [IDX_W-1:0] r_didx;
    logic [VAL_W-1:0] r_pv;

    logic             w_accept;
    logic [VAL_W-1:0] w_clamped;
    logic             w_empty;
    t_msb_req         msb_req;
    t_msb_rsp         msb_rsp;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [63:0]      ram_rdata;
    logic [63:0]      n_seen;
    logic             w_hit;
    logic [64:0]      n_prod;
    logic [64:0]      n_sum;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_clamped = i_sample_value[63] ? '0 : i_sample_value[VAL_W-1:0];
    assign w_empty   = (r_count == 64'd0);

    assign msb_req.go    = w_accept && (i_func == FN_RECORD) && (i_occurrence_count != 32'd0);
    assign msb_req.value = w_clamped;

    llh_msb u_msb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (msb_req),
        .o_rsp   (msb_rsp)
    );

    always_comb begin
        mul_a = r_v[31:0];
        mul_b = r_occ;
        case (r_state)
            S_MUL1: mul_a = {1'b0, r_v[VAL_W-1:32]};
            S_QM0: begin
                mul_a = r_count[31:0];
                mul_b = {16'd0, r_q};
            end
            S_QM1: begin
                mul_a = r_count[63:32];
                mul_b = {16'd0, r_q};
            end
            default: ;
        endcase
    end

    llh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata + {32'd0, r_occ};
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = '0;
            end
            S_UPD:   ram_we = 1'b1;
            default: ;
        endcase
    end

    assign ram_raddr = (r_state == S_WALK) ? r_ptr : r_idx;

    llh_ram #(
        .WIDTH (64),
        .DEPTH (BUCKET_COUNT)
    ) u_buckets (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign n_seen = r_seen + ram_rdata;
    assign w_hit  = r_dv && (n_seen >= r_target);
    assign n_prod = {1'b0, r_plo} + {1'b0, mul_p[31:0], 32'd0};
    assign n_sum  = {1'b0, r_sum} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_strobe  <= 1'b0;
            r_clr_rpt <= 1'b0;
            r_ptr     <= '0;
            r_live    <= 1'b0;
            r_dv      <= 1'b0;
            r_count   <= '0;
            r_sum     <= '0;
            r_max     <= '0;
            r_min     <= MAX63;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pv  <= '0;
                        r_v   <= w_clamped;
                        r_occ <= i_occurrence_count;
                        r_q   <= i_quantile_q16[15:0];
                        case (i_func)
                            FN_RECORD: begin
                                if (i_occurrence_count == 32'd0) r_strobe <= 1'b1;
                                else r_state <= S_SRCH;
                            end
                            FN_QUERY: begin
                                if (w_empty) begin
                                    r_strobe <= 1'b1;
                                end else if (i_quantile_q16[16]) begin
                                    r_target <= r_count;
                                    r_state  <= S_QCLP;
                                end else begin
                                    r_state <= S_QM0;
                                end
                            end
                            FN_CLEAR: begin
                                r_count   <= '0;
                                r_sum     <= '0;
                                r_max     <= '0;
                                r_min     <= MAX63;
                                r_ptr     <= '0;
                                r_clr_rpt <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: r_strobe <= 1'b1;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_ptr == IDX_W'(LAST_IDX)) begin
                        r_strobe <= r_clr_rpt;
                        r_state  <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_SRCH: begin
                    if (msb_rsp.done) r_state <= S_IDX;
                end
                S_IDX: begin
                    r_idx   <= bucket_index(r_v, msb_rsp.e);
                    r_state <= S_MUL0;
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: begin
                    r_plo   <= mul_p;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_prod  <= n_prod[63:0];
                    r_psat  <= n_prod[64] || (mul_p[63:32] != 32'd0);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum    <= (n_sum[64] || r_psat) ? '1 : n_sum[63:0];
                    r_count  <= r_count + {32'd0, r_occ};
                    if (r_v > r_max) r_max <= r_v;
                    if (r_v < r_min) r_min <= r_v;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_QM0: r_state <= S_QM1;
                S_QM1: begin
                    r_plo   <= mul_p + 64'd32768;
                    r_state <= S_QTGT;
                end
                S_QTGT: begin
                    r_target <= {mul_p[47:0], 16'd0} + {16'd0, r_plo[63:16]};
                    r_state  <= S_QCLP;
                end
                S_QCLP: begin
                    if (r_target == 64'd0) r_target <= 64'd1;
                    else if (r_target > r_count) r_target <= r_count;
                    r_seen  <= '0;
                    r_ptr   <= '0;
                    r_live  <= 1'b1;
                    r_dv    <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_dv   <= r_live;
                    r_didx <= r_ptr;
                    if (r_live) begin
                        if (r_ptr == IDX_W'(LAST_IDX)) r_live <= 1'b0;
                        else r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_dv) r_seen <= n_seen;
                    if (w_hit) begin
                        r_idx   <= r_didx;
                        r_dv    <= 1'b0;
                        r_state <= S_BND;
                    end else if (r_dv && (r_didx == IDX_W'(LAST_IDX))) begin
                        r_pv     <= r_max;
                        r_dv     <= 1'b0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_BND: begin
                    r_pv    <= bucket_upper(r_idx);
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    if (r_max < r_pv) r_pv <= r_max;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe           = r_strobe;
    assign o_percentile_value = r_pv;
    assign o_total_count      = r_count;
    assign o_sum_total        = r_sum;
    assign o_min_seen         = w_empty ? '0 : r_min;
    assign o_max_seen         = w_empty ? '0 : r_max;
    assign o_is_empty         = w_empty;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word shown while sequencer busy");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FN_CLEAR)) |=> (busy && o_is_empty && (o_sum_total == 64'd0)))
        else $error("clear did not empty the histogram");

    a_empty_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_empty) |-> (o_percentile_value == '0))
        else $error("nonzero percentile on empty histogram");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_ptr <= IDX_W'(LAST_IDX)) && (r_target != 64'd0)))
        else $error("bucket walk out of range or zero rank");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the log-linear latency histogram: directed and random words.
module tb_top;
    import llh_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 2000;

    typedef struct {
        logic [62:0] pct;
        logic [63:0] total;
        logic [63:0] sum;
        logic [62:0] lo;
        logic [62:0] hi;
        logic        empty;
    } t_result_word;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        start              = 1'b0;
    logic [1:0]  i_func             = '0;
    logic [63:0] i_sample_value     = '0;
    logic [31:0] i_occurrence_count = '0;
    logic [16:0] i_quantile_q16     = '0;
    logic        busy;
    logic        o_strobe;
    logic [62:0] o_percentile_value;
    logic [63:0] o_total_count;
    logic [63:0] o_sum_total;
    logic [62:0] o_min_seen;
    logic [62:0] o_max_seen;
    logic        o_is_empty;

    log_linear_latency_histogram_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_sample_value     (i_sample_value),
        .i_occurrence_count (i_occurrence_count),
        .i_quantile_q16     (i_quantile_q16),
        .o_strobe           (o_strobe),
        .o_percentile_value (o_percentile_value),
        .o_total_count      (o_total_count),
        .o_sum_total        (o_sum_total),
        .o_min_seen         (o_min_seen),
        .o_max_seen         (o_max_seen),
        .o_is_empty         (o_is_empty)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow histogram
    logic [63:0]  hist_bins [BUCKET_COUNT];
    logic [63:0]  hist_count;
    logic [63:0]  hist_sum;
    logic [62:0]  hist_max;
    logic [62:0]  hist_min;
    t_result_word expected_words[$];
    t_result_word want_word;
    int           mismatches  = 0;
    int           stall_cycles = 0;
    int           idle_pct    = 0;

    task automatic clear_history();
        for (int i = 0; i < BUCKET_COUNT; i++) hist_bins[i] = '0;
        hist_count = '0;
        hist_sum   = '0;
        hist_max   = '0;
        hist_min   = MAX63;
    endtask

    function automatic int leading_one(input logic [63:0] v);
        int e;
        e = 0;
        for (int k = 1; k < 64; k++) begin
            if ((v >> k) != 0) e = k;
        end
        return e;
    endfunction

    function automatic int bin_of(input logic [63:0] v);
        int          shift;
        logic [63:0] idx;
        if (v < 64'(LINEAR_LIMIT)) return int'(v);
        shift = leading_one(v) - SUB_BUCKET_BITS;
        if (shift < 1) shift = 1;
        idx = 64'(LINEAR_LIMIT) + 64'((shift - 1) * SUB_COUNT)
            + ((v >> shift) & 64'(SUB_COUNT - 1));
        if (idx > 64'(BUCKET_COUNT - 1)) idx = 64'(BUCKET_COUNT - 1);
        return int'(idx);
    endfunction

    function automatic logic [62:0] bin_ceiling(input int idx);
        int          off;
        int          shift;
        int          sub;
        logic [63:0] b;
        if (idx < LINEAR_LIMIT) return 63'(idx);
        off   = idx - LINEAR_LIMIT;
        shift = off / SUB_COUNT + 1;
        sub   = off % SUB_COUNT;
        if (shift + SUB_BUCKET_BITS + 1 > 63) return MAX63;
        b = (64'(SUB_COUNT + sub) << shift) + ((64'd1 << shift) - 64'd1);
        return b[62:0];
    endfunction

    function automatic logic [62:0] percentile_of(input logic [16:0] q);
        logic [81:0] wide;
        logic [63:0] target;
        logic [63:0] seen;
        logic [62:0] bound;
        if (hist_count == 0) return '0;
        if (q >= 17'd65536) begin
            target = hist_count;
        end else begin
            wide   = 82'(q) * 82'(hist_count) + 82'd32768;
            target = wide[79:16];
        end
        if (target < 64'd1) target = 64'd1;
        if (target > hist_count) target = hist_count;
        seen = '0;
        for (int i = 0; i < BUCKET_COUNT; i++) begin
            seen += hist_bins[i];
            if (seen >= target) begin
                bound = bin_ceiling(i);
                return (bound < hist_max) ? bound : hist_max;
            end
        end
        return hist_max;
    endfunction

    task automatic predict_word(input logic [1:0] f, input logic [63:0] raw,
                                input logic [31:0] occ, input logic [16:0] q);
        logic [62:0]  v;
        logic [95:0]  prod;
        logic [64:0]  acc;
        t_result_word w;
        w.pct = '0;
        case (f)
            FN_RECORD: begin
                if (occ != 0) begin
                    v = raw[63] ? '0 : raw[62:0];
                    hist_bins[bin_of({1'b0, v})] += 64'(occ);
                    hist_count += 64'(occ);
                    prod = 96'(v) * 96'(occ);
                    if (prod[95:64] != 0) prod[63:0] = '1;
                    acc = 65'(hist_sum) + 65'(prod[63:0]);
                    hist_sum = acc[64] ? '1 : acc[63:0];
                    if (v > hist_max) hist_max = v;
                    if (v < hist_min) hist_min = v;
                end
            end
            FN_QUERY: w.pct = percentile_of(q);
            FN_CLEAR: clear_history();
            default: ;
        endcase
        w.total = hist_count;
        w.sum   = hist_sum;
        w.lo    = (hist_count == 0) ? '0 : hist_min;
        w.hi    = (hist_count == 0) ? '0 : hist_max;
        w.empty = (hist_count == 0);
        expected_words.push_back(w);
    endtask

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // predict on accept, check on strobe, watch for stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                predict_word(i_func, i_sample_value, i_occurrence_count, i_quantile_q16);
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    flag("unexpected word", '0, {63'd0, o_strobe});
                end else begin
                    want_word = expected_words.pop_front();
                    if (want_word.pct !== o_percentile_value)
                        flag("percentile_value", 64'(want_word.pct), 64'(o_percentile_value));
                    if (want_word.total !== o_total_count)
                        flag("total_count", want_word.total, o_total_count);
                    if (want_word.sum !== o_sum_total)
                        flag("sum_total", want_word.sum, o_sum_total);
                    if (want_word.lo !== o_min_seen)
                        flag("min_seen", 64'(want_word.lo), 64'(o_min_seen));
                    if (want_word.hi !== o_max_seen)
                        flag("max_seen", 64'(want_word.hi), 64'(o_max_seen));
                    if (want_word.empty !== o_is_empty)
                        flag("is_empty", 64'(want_word.empty), 64'(o_is_empty));
                end
            end
            if ((start && !busy) || o_strobe) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] f, input logic [63:0] s,
                             input logic [31:0] n, input logic [16:0] q);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start              <= 1'b1;
        i_func             <= f;
        i_sample_value     <= s;
        i_occurrence_count <= n;
        i_quantile_q16     <= q;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic test_empty_and_unused();
        send_word(FN_QUERY, 64'd500, 32'd1, 17'd32768);
        send_word(FN_UNUSED, '1, '1, '1);
    endtask

    task automatic test_record_extremes();
        send_word(FN_RECORD, 64'd0, 32'd1, '0);
        send_word(FN_RECORD, 64'd63, 32'd1, '0);
        send_word(FN_RECORD, 64'd64, 32'd1, '0);
        send_word(FN_RECORD, '1, 32'd5, '0);
        send_word(FN_RECORD, 64'h8000_0000_0000_0000, 32'd1, '0);
        send_word(FN_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1, '0);
        send_word(FN_RECORD, 64'd1000, 32'd0, '0);
        // large product drives the sum into saturation
        send_word(FN_RECORD, 64'h0000_0100_0000_0000, 32'hFFFF_FFFF, '0);
    endtask

    task automatic test_quantile_edges();
        send_word(FN_QUERY, '0, '0, 17'd0);
        send_word(FN_QUERY, '0, '0, 17'd1);
        send_word(FN_QUERY, '0, '0, 17'd32768);
        send_word(FN_QUERY, '0, '0, 17'd65535);
        send_word(FN_QUERY, '0, '0, 17'd65536);
        send_word(FN_QUERY, '0, '0, 17'h1FFFF);
    endtask

    task automatic test_clear_and_refill();
        send_word(FN_CLEAR, '0, '0, '0);
        send_word(FN_QUERY, '0, '0, 17'd65536);
        send_word(FN_RECORD, 64'd100, 32'd3, '0);
        send_word(FN_QUERY, '0, '0, 17'd65536);
    endtask

    task automatic test_random_traffic(input int count, input int pct);
        int          sel;
        int          pw;
        logic [1:0]  f;
        logic [63:0] s;
        logic [31:0] n;
        logic [16:0] q;
        idle_pct = pct;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            f = (sel < 60) ? FN_RECORD : (sel < 91) ? FN_QUERY :
                (sel < 96) ? FN_UNUSED : FN_CLEAR;
            case ($urandom_range(9))
                0, 1, 2: s = 64'($urandom_range(63));
                3, 4:    s = 64'($urandom_range(1 << 20, 64));
                5:       s = {$urandom, $urandom} >> $urandom_range(63, 1);
                6:       s = {$urandom, $urandom};
                7:       s = -64'($urandom_range(1000, 1));
                8: begin
                    pw = $urandom_range(62, 6);
                    s  = (64'd1 << pw) - 64'd1 + 64'($urandom_range(2));
                end
                default: s = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
            endcase
            case ($urandom_range(9))
                0:       n = '0;
                1:       n = $urandom;
                2:       n = 32'hFFFF_FFFF - 32'($urandom_range(15));
                default: n = 32'($urandom_range(20, 1));
            endcase
            case ($urandom_range(7))
                0:       q = '0;
                1:       q = 17'd65536;
                2:       q = 17'($urandom_range(131071, 65537));
                3:       q = 17'd65535;
                default: q = 17'($urandom_range(65535));
            endcase
            send_word(f, s, n, q);
        end
    endtask

    initial begin
        clear_history();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 25;
        test_empty_and_unused();
        test_record_extremes();
        test_quantile_edges();
        test_clear_and_refill();
        test_random_traffic(270, 25);
        test_random_traffic(270, 52);
        test_random_traffic(260, 0);
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_words.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/llh_pkg.sv
src/llh_ram.sv
src/llh_mul.sv
src/llh_msb.sv
src/log_linear_latency_histogram_unit.sv
dv/tb_top.sv
